### sv/smau_pkg.sv
package smau_pkg;

	// Access opcodes
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_STORE = 2'd1,
		OP_EVENT = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Access size codes; the other two codes both act as a word
	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;

	// Region codes
	typedef enum logic [2:0] {
		REG_NONE    = 3'd0,
		REG_TEXT    = 3'd1,
		REG_DATA    = 3'd2,
		REG_HEAP    = 3'd3,
		REG_BUTTONS = 3'd4
	} region_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_MISALIGN = 2'd2,
		ST_RDONLY   = 2'd3
	} status_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_BASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_ENDIAN = 3'd4;

	// Reset values of the configuration registers
	localparam logic [31:0] TEXT_BASE_RST   = 32'h0000_0000;
	localparam logic [31:0] DATA_BASE_RST   = 32'h0011_0000;
	localparam logic [31:0] HEAP_BASE_RST   = 32'h0012_0000;
	localparam logic [31:0] BUTTON_BASE_RST = 32'hffff_0000;

	localparam int BUTTON_BYTES = 4;

	typedef struct packed {
		logic [31:0] text_base;
		logic [31:0] data_base;
		logic [31:0] heap_base;
		logic [31:0] button_base;
		logic        little_endian;
	} cfg_t;

	// Offset of the last byte of an access (bytes minus one)
	function automatic logic [1:0] last_offset(logic [1:0] size);
		logic [1:0] m;
		unique case (size)
			SZ_BYTE: m = 2'd0;
			SZ_HALF: m = 2'd1;
			default: m = 2'd3;
		endcase
		return m;
	endfunction

endpackage

### sv/smau_if.sv
interface smau_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [1:0]  access_size;
	logic [31:0] address;
	logic [31:0] store_data;
	logic        zero_extend;
	logic [3:0]  key_number;
	logic        controller;
	logic        key_down;

	modport source (output valid, op, access_size, address, store_data, zero_extend,
		key_number, controller, key_down, input ready);
	modport sink (input valid, op, access_size, address, store_data, zero_extend,
		key_number, controller, key_down, output ready);
endinterface

interface smau_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] load_data;
	logic [1:0]  status;
	logic [2:0]  region;

	modport source (output valid, load_data, status, region, input ready);
	modport sink (input valid, load_data, status, region, output ready);
endinterface

interface smau_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/smau_byte_ram.sv
module smau_byte_ram #(
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Single port, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### sv/smau_region_dec.sv
module smau_region_dec #(
	parameter int TEXT_BYTES = 65536,
	parameter int DATA_BYTES = 65536,
	parameter int HEAP_BYTES = 65536,
	parameter int OFF_W      = 16
) (
	input  smau_pkg::cfg_t    cfg,
	input  logic [31:0]       addr,
	output smau_pkg::region_t region,
	output logic [OFF_W-1:0]  off
);

	logic [31:0] d_text, d_data, d_heap, d_btn, diff;

	assign d_text = addr - cfg.text_base;
	assign d_data = addr - cfg.data_base;
	assign d_heap = addr - cfg.heap_base;
	assign d_btn  = addr - cfg.button_base;

	// First matching window wins: text, data, heap, buttons
	always_comb begin
		if (addr >= cfg.text_base && d_text < 32'(TEXT_BYTES)) begin
			region = smau_pkg::REG_TEXT;
			diff   = d_text;
		end else if (addr >= cfg.data_base && d_data < 32'(DATA_BYTES)) begin
			region = smau_pkg::REG_DATA;
			diff   = d_data;
		end else if (addr >= cfg.heap_base && d_heap < 32'(HEAP_BYTES)) begin
			region = smau_pkg::REG_HEAP;
			diff   = d_heap;
		end else if (addr >= cfg.button_base && d_btn < 32'(smau_pkg::BUTTON_BYTES)) begin
			region = smau_pkg::REG_BUTTONS;
			diff   = d_btn;
		end else begin
			region = smau_pkg::REG_NONE;
			diff   = '0;
		end
	end

	assign off = diff[OFF_W-1:0];

endmodule

### sv/segmented_memory_access_unit.sv
// Steps: accept, decode first byte, decode last byte and check range and alignment;
// in range, one step per byte, then drain and finish; a fault finishes after the
// check, an event or unused opcode after the first decode. One item at a time;
// each store's single byte-wide port is visited once per byte, the decoder is shared.
// Reset: asynchronous, active low; then a clearing pass over max(TEXT_BYTES,
// DATA_BYTES, HEAP_BYTES) addresses zeroes the stores before the first item is taken.
module segmented_memory_access_unit #(
	parameter int TEXT_BYTES = 65536,
	parameter int DATA_BYTES = 65536,
	parameter int HEAP_BYTES = 65536
) (
	input logic          clk,
	input logic          arst_n,
	smau_req_if.sink     req,
	smau_rsp_if.source   rsp,
	smau_cfg_if.sink     cfg
);

	localparam int MAX_TD    = (TEXT_BYTES > DATA_BYTES) ? TEXT_BYTES : DATA_BYTES;
	localparam int MAX_BYTES = (MAX_TD > HEAP_BYTES) ? MAX_TD : HEAP_BYTES;
	localparam int OFF_W     = $clog2(MAX_BYTES);
	localparam int TEXT_AW   = $clog2(TEXT_BYTES);
	localparam int DATA_AW   = $clog2(DATA_BYTES);
	localparam int HEAP_AW   = $clog2(HEAP_BYTES);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_FIRST = 7'b0000100,
		S_LAST  = 7'b0001000,
		S_BYTE  = 7'b0010000,
		S_DRAIN = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                state_q;
	smau_pkg::cfg_t        cfg_q;
	logic [OFF_W-1:0]      clr_q;

	// Captured item
	smau_pkg::op_t         op_q;
	logic [1:0]            mask_q;
	logic [31:0]           addr_q;
	logic [31:0]           sdata_q;
	logic                  zext_q;
	logic [3:0]            key_q;
	logic                  ctl_q;
	logic                  kdown_q;

	// Working state of the access
	logic [1:0]            idx_q;
	smau_pkg::region_t     first_q;
	logic [31:0]           val_q;
	smau_pkg::status_t     status_q;
	smau_pkg::region_t     region_q;
	logic [15:0]           btn_q [2];

	// Load byte in flight
	logic                  ld_s1;
	smau_pkg::region_t     src_s1;
	logic [1:0]            lane_s1;
	logic [7:0]            bbyte_s1;

	// Result register
	logic                  rsp_valid_q;
	logic [31:0]           rsp_data_q;
	smau_pkg::status_t     rsp_status_q;
	smau_pkg::region_t     rsp_region_q;

	logic [1:0]            inc;
	logic [31:0]           dec_addr;
	smau_pkg::region_t     dec_region;
	logic [OFF_W-1:0]      dec_off;
	logic [1:0]            lane;
	logic [7:0]            st_byte;
	logic [15:0]           btn_word;
	logic [7:0]            bbyte;
	logic [7:0]            rd_byte;
	logic [31:0]           ext_val;
	logic                  clearing, do_store;
	logic                  rsp_load;
	logic                  text_we, data_we, heap_we;
	logic [TEXT_AW-1:0]    text_addr;
	logic [DATA_AW-1:0]    data_addr;
	logic [HEAP_AW-1:0]    heap_addr;
	logic [7:0]            wbyte;
	logic [7:0]            text_rd, data_rd, heap_rd;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.load_data = rsp_data_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.region    = rsp_region_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_base     <= smau_pkg::TEXT_BASE_RST;
			cfg_q.data_base     <= smau_pkg::DATA_BASE_RST;
			cfg_q.heap_base     <= smau_pkg::HEAP_BASE_RST;
			cfg_q.button_base   <= smau_pkg::BUTTON_BASE_RST;
			cfg_q.little_endian <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				smau_pkg::CFG_TEXT_BASE:     cfg_q.text_base     <= cfg.data;
				smau_pkg::CFG_DATA_BASE:     cfg_q.data_base     <= cfg.data;
				smau_pkg::CFG_HEAP_BASE:     cfg_q.heap_base     <= cfg.data;
				smau_pkg::CFG_BUTTON_BASE:   cfg_q.button_base   <= cfg.data;
				smau_pkg::CFG_LITTLE_ENDIAN: cfg_q.little_endian <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Shared decoder: first byte, last byte, then each byte in turn
	always_comb begin
		if (state_q == S_LAST) begin
			inc = mask_q;
		end else if (state_q == S_BYTE) begin
			inc = idx_q;
		end else begin
			inc = 2'd0;
		end
	end

	assign dec_addr = addr_q + {30'b0, inc};

	smau_region_dec #(
		.TEXT_BYTES (TEXT_BYTES),
		.DATA_BYTES (DATA_BYTES),
		.HEAP_BYTES (HEAP_BYTES),
		.OFF_W      (OFF_W)
	) u_dec (
		.cfg    (cfg_q),
		.addr   (dec_addr),
		.region (dec_region),
		.off    (dec_off)
	);

	// Byte lane within the value for the current byte
	assign lane     = cfg_q.little_endian ? idx_q : (mask_q - idx_q);
	assign st_byte  = 8'(sdata_q >> {lane, 3'b000});
	assign btn_word = btn_q[dec_off[1]];
	assign bbyte    = dec_off[0] ? btn_word[15:8] : btn_word[7:0];

	// Store port muxing: clearing pass or one store byte
	assign clearing  = (state_q == S_CLEAR);
	assign do_store  = (state_q == S_BYTE) && (op_q == smau_pkg::OP_STORE);
	assign wbyte     = clearing ? 8'h00 : st_byte;
	assign text_we   = clearing ? (32'(clr_q) < 32'(TEXT_BYTES))
		: (do_store && dec_region == smau_pkg::REG_TEXT);
	assign data_we   = clearing ? (32'(clr_q) < 32'(DATA_BYTES))
		: (do_store && dec_region == smau_pkg::REG_DATA);
	assign heap_we   = clearing ? (32'(clr_q) < 32'(HEAP_BYTES))
		: (do_store && dec_region == smau_pkg::REG_HEAP);
	assign text_addr = clearing ? clr_q[TEXT_AW-1:0] : dec_off[TEXT_AW-1:0];
	assign data_addr = clearing ? clr_q[DATA_AW-1:0] : dec_off[DATA_AW-1:0];
	assign heap_addr = clearing ? clr_q[HEAP_AW-1:0] : dec_off[HEAP_AW-1:0];

	smau_byte_ram #(.DEPTH(TEXT_BYTES)) u_text (
		.clk(clk), .we(text_we), .addr(text_addr), .wdata(wbyte), .rdata(text_rd)
	);
	smau_byte_ram #(.DEPTH(DATA_BYTES)) u_data (
		.clk(clk), .we(data_we), .addr(data_addr), .wdata(wbyte), .rdata(data_rd)
	);
	smau_byte_ram #(.DEPTH(HEAP_BYTES)) u_heap (
		.clk(clk), .we(heap_we), .addr(heap_addr), .wdata(wbyte), .rdata(heap_rd)
	);

	// Byte returning from the read issued last cycle
	always_comb begin
		unique case (src_s1)
			smau_pkg::REG_TEXT:    rd_byte = text_rd;
			smau_pkg::REG_DATA:    rd_byte = data_rd;
			smau_pkg::REG_HEAP:    rd_byte = heap_rd;
			smau_pkg::REG_BUTTONS: rd_byte = bbyte_s1;
			default:               rd_byte = 8'h00;
		endcase
	end

	// Sign extension of byte and halfword loads that do not ask for zero extension
	always_comb begin
		ext_val = val_q;
		if (op_q == smau_pkg::OP_LOAD && !zext_q) begin
			if (mask_q == 2'd0) begin
				ext_val = {{24{val_q[7]}}, val_q[7:0]};
			end else if (mask_q == 2'd1) begin
				ext_val = {{16{val_q[15]}}, val_q[15:0]};
			end
		end
	end

	// New result beat when the output register is free or being taken
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			op_q         <= smau_pkg::OP_NONE;
			mask_q       <= 2'd0;
			addr_q       <= '0;
			sdata_q      <= '0;
			zext_q       <= 1'b0;
			key_q        <= '0;
			ctl_q        <= 1'b0;
			kdown_q      <= 1'b0;
			idx_q        <= 2'd0;
			first_q      <= smau_pkg::REG_NONE;
			val_q        <= '0;
			status_q     <= smau_pkg::ST_OK;
			region_q     <= smau_pkg::REG_NONE;
			btn_q[0]     <= '0;
			btn_q[1]     <= '0;
			ld_s1        <= 1'b0;
			src_s1       <= smau_pkg::REG_NONE;
			lane_s1      <= 2'd0;
			bbyte_s1     <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_data_q   <= '0;
			rsp_status_q <= smau_pkg::ST_OK;
			rsp_region_q <= smau_pkg::REG_NONE;
		end else begin
			ld_s1 <= (state_q == S_BYTE) && (op_q == smau_pkg::OP_LOAD);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (ld_s1) begin
				val_q <= val_q | (32'(rd_byte) << {lane_s1, 3'b000});
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + OFF_W'(1);
					if (clr_q == OFF_W'(MAX_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= smau_pkg::op_t'(req.op);
						mask_q   <= smau_pkg::last_offset(req.access_size);
						addr_q   <= req.address;
						sdata_q  <= req.store_data;
						zext_q   <= req.zero_extend;
						key_q    <= req.key_number;
						ctl_q    <= req.controller;
						kdown_q  <= req.key_down;
						val_q    <= '0;
						status_q <= smau_pkg::ST_OK;
						region_q <= smau_pkg::REG_NONE;
						state_q  <= S_FIRST;
					end
				end
				S_FIRST: begin
					first_q <= dec_region;
					if (op_q == smau_pkg::OP_EVENT) begin
						btn_q[ctl_q][key_q] <= kdown_q;
						state_q <= S_DONE;
					end else if (op_q == smau_pkg::OP_NONE) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (first_q == smau_pkg::REG_NONE || dec_region == smau_pkg::REG_NONE) begin
						status_q <= smau_pkg::ST_RANGE;
						state_q  <= S_DONE;
					end else if ((addr_q[1:0] & mask_q) != 2'd0) begin
						status_q <= smau_pkg::ST_MISALIGN;
						region_q <= first_q;
						state_q  <= S_DONE;
					end else begin
						region_q <= first_q;
						idx_q    <= 2'd0;
						state_q  <= S_BYTE;
					end
				end
				S_BYTE: begin
					if (op_q == smau_pkg::OP_LOAD) begin
						src_s1   <= dec_region;
						lane_s1  <= lane;
						bbyte_s1 <= bbyte;
					end else if (dec_region == smau_pkg::REG_BUTTONS) begin
						status_q <= smau_pkg::ST_RDONLY;
					end
					if (idx_q == mask_q) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_data_q   <= ext_val;
						rsp_status_q <= status_q;
						rsp_region_q <= region_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A returning load byte follows a byte step of the sequencer
	a_ld_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s1 |-> (state_q == S_BYTE || state_q == S_DRAIN))
		else $error("load byte in flight outside the byte steps");

	// A range fault reports no region and no data
	a_range_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == smau_pkg::ST_RANGE)
		|-> (rsp.region == smau_pkg::REG_NONE && rsp.load_data == 32'd0))
		else $error("range fault with region or data");

	// A new result is only produced from the finishing state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside the finishing state");
`endif

endmodule
